// ===== rtl/mm128_pkg.sv =====
// shared types, codes and sizing helpers for the 128-bit montgomery multiplier
// no dependencies
package mm128_pkg;

  localparam int OPERAND_BITS_DEF = 128;
  localparam int REG_INDEX_BITS   = 3;

  localparam logic [1:0] FUNC_MUL       = 2'd0;
  localparam logic [1:0] FUNC_TO_MONT   = 2'd1;
  localparam logic [1:0] FUNC_FROM_MONT = 2'd2;

  localparam logic [REG_INDEX_BITS-1:0] REG_MOD_LO  = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_MOD_HI  = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_NINV_LO = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_NINV_HI = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_RSQ_LO  = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_RSQ_HI  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
  } mm_cmd_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        fault;
  } mm_res_t;

  // operand width in whole 64-bit limbs, one to four limbs
  function automatic int mm_width(input int bits);
    int limbs;
    limbs = bits / 64;
    if (limbs < 1) limbs = 1;
    if (limbs > 4) limbs = 4;
    return limbs * 64;
  endfunction

  // multiplier pipeline stages: the product stage plus the adder tree levels
  function automatic int mm_mul_lat(input int w);
    return 1 + $clog2(w / 16);
  endfunction

endpackage

// ===== rtl/mm128_mul.sv =====
// pipelined w x w multiplier: 32x32 partial products, then a registered adder tree
// depends on mm128_pkg for the latency formula
module mm128_mul #(
  parameter int W  = 128,
  parameter int PW = 256
) (
  input  logic          clk,
  input  logic [W-1:0]  x,
  input  logic [W-1:0]  y,
  output logic [PW-1:0] p
);
  import mm128_pkg::*;

  localparam int K  = W / 32;
  localparam int LV = $clog2(2 * K);
  localparam int NP = 2 ** LV;

  logic [63:0]   pp   [K][K];
  logic [PW-1:0] lvl0 [NP];
  logic [PW-1:0] tree [LV][NP];

  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        pp[i][j] <= 64'(x[32*i +: 32]) * 64'(y[32*j +: 32]);
      end
    end
  end

  // columns of a row with the same parity do not overlap, so they merge by or
  always_comb begin
    for (int n = 0; n < NP; n++) begin
      lvl0[n] = '0;
    end
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        lvl0[2*i + (j % 2)] = lvl0[2*i + (j % 2)] | (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar n = 0; n < NP; n++) begin : g_node
      if (n < (NP >> (l + 1))) begin : g_add
        if (l == 0) begin : g_first
          always_ff @(posedge clk) begin
            tree[l][n] <= lvl0[2*n] + lvl0[2*n+1];
          end
        end else begin : g_rest
          always_ff @(posedge clk) begin
            tree[l][n] <= tree[l-1][2*n] + tree[l-1][2*n+1];
          end
        end
      end else begin : g_zero
        assign tree[l][n] = '0;
      end
    end
  end

  assign p = tree[LV-1][0];

  localparam int LAT_CHECK = mm_mul_lat(W);
  logic unused_lat;
  assign unused_lat = (LAT_CHECK == 1 + LV);

endmodule

// ===== rtl/montgomery_multiplier_128.sv =====
// top level of the montgomery multiplier, R = 2^W, W being OPERAND_BITS in whole 64-bit limbs
// depends on mm128_pkg and mm128_mul
//
// channel  signals                          transaction
// input    start, busy, cmd                 start high while busy low
// output   done, result                     done high, one cycle
// config   cfg_write, cfg_index, cfg_data   cfg_write high
//
// one transaction per cycle; busy stays low
// a result passes the input register, the three chained multipliers and their
// adder trees, the sum stage and the final subtract stage
// rst clears the valid pipe and sets the config registers to their reset values
// results cannot be held off
module montgomery_multiplier_128 #(
  parameter int OPERAND_BITS = mm128_pkg::OPERAND_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mm128_pkg::mm_cmd_t                  cmd,
  output logic                                done,
  output mm128_pkg::mm_res_t                  result,
  input  logic                                cfg_write,
  input  logic [mm128_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  logic [63:0]                         cfg_data
);
  import mm128_pkg::*;

  localparam int W   = mm_width(OPERAND_BITS);
  localparam int L   = mm_mul_lat(W);
  localparam int LAT = 3 * L + 3;

  logic [63:0] modulus_low, modulus_high;
  logic [63:0] neg_inverse_low, neg_inverse_high;
  logic [63:0] r_squared_low, r_squared_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_low      <= 64'd1;
      modulus_high     <= 64'd0;
      neg_inverse_low  <= 64'd0;
      neg_inverse_high <= 64'd0;
      r_squared_low    <= 64'd0;
      r_squared_high   <= 64'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOD_LO:  modulus_low      <= cfg_data;
        REG_MOD_HI:  modulus_high     <= cfg_data;
        REG_NINV_LO: neg_inverse_low  <= cfg_data;
        REG_NINV_HI: neg_inverse_high <= cfg_data;
        REG_RSQ_LO:  r_squared_low    <= cfg_data;
        REG_RSQ_HI:  r_squared_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [W-1:0] m_w, mp_w, y_sel;
  assign m_w  = W'({modulus_high, modulus_low});
  assign mp_w = W'({neg_inverse_high, neg_inverse_low});

  always_comb begin
    case (cmd.func)
      FUNC_TO_MONT:   y_sel = W'({r_squared_high, r_squared_low});
      FUNC_FROM_MONT: y_sel = W'(1);
      default:        y_sel = W'({cmd.b_high, cmd.b_low});
    endcase
  end

  assign busy = 1'b0;

  // valid pipe
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // input stage
  logic [W-1:0] a_r, y_r;
  always_ff @(posedge clk) begin
    a_r <= W'({cmd.a_high, cmd.a_low});
    y_r <= y_sel;
  end

  logic [2*W-1:0] t, qm;
  logic [W-1:0]   lq;

  mm128_mul #(.W(W), .PW(2*W)) u_mul_t (.clk(clk), .x(a_r), .y(y_r), .p(t));
  mm128_mul #(.W(W), .PW(W)) u_mul_q (.clk(clk), .x(t[W-1:0]), .y(mp_w), .p(lq));
  mm128_mul #(.W(W), .PW(2*W)) u_mul_m (.clk(clk), .x(lq), .y(m_w), .p(qm));

  // t waits for the two reduction products
  logic [2*W-1:0] t_dly [2*L];
  always_ff @(posedge clk) begin
    t_dly[0] <= t;
    for (int k = 1; k < 2 * L; k++) begin
      t_dly[k] <= t_dly[k-1];
    end
  end

  // sum stage
  logic [2*W:0] s;
  logic [W-1:0] u_r;
  logic         fault_r;
  assign s = {1'b0, t_dly[2*L-1]} + {1'b0, qm};
  always_ff @(posedge clk) begin
    u_r     <= s[2*W-1:W];
    fault_r <= s[2*W] | (s[W-1:0] != '0);
  end

  // final subtract stage
  logic [W:0]   diff;
  logic [W-1:0] res_w, res_r;
  logic         fault_o;
  assign diff = {1'b0, u_r} - {1'b0, m_w};
  always_comb begin
    if (fault_r) begin
      res_w = '0;
    end else if (!diff[W]) begin
      res_w = diff[W-1:0];
    end else begin
      res_w = u_r;
    end
  end
  always_ff @(posedge clk) begin
    res_r   <= res_w;
    fault_o <= fault_r;
  end

  logic [127:0] res_128;
  assign res_128 = 128'(res_r);

  assign done               = vld[LAT-1];
  assign result.result_low  = res_128[63:0];
  assign result.result_high = res_128[127:64];
  assign result.fault       = fault_o;

endmodule
